[design/afcr_pkg.sv]
package afcr_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // extra fraction bits on coordinates inside the vectoring cordic
  localparam int GUARD_BITS = 8;

  localparam int RADIUS_W  = 31;
  localparam int CFG_IDX_W = 8;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

  // 1/K of the cordic, q32 and q30
  localparam logic [31:0] INV_GAIN     = 32'd2608131496;
  localparam logic [32:0] INV_GAIN_Q30 = 33'd652032874;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_RADIUS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SIDE = 8'd3;

  // atan(2^-i) in 2^-32 turn
  localparam logic [31:0] ATAN_TURN [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

[design/afcr_if.sv]
interface afcr_cfg_if #(
  parameter int DW = 32
);
  logic                           valid;
  logic                           ready;
  logic [afcr_pkg::CFG_IDX_W-1:0] index;
  logic [DW-1:0]                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface afcr_in_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic                 flip_direction;

  modport source (output valid, output end_x, output end_y, output flip_direction,
                  input ready);
  modport sink (input valid, input end_x, input end_y, input flip_direction,
                output ready);
endinterface

interface afcr_out_if #(
  parameter int CW = 32,
  parameter int AW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic                 arc_reversed;
  logic [AW-1:0]        start_angle;
  logic [AW-1:0]        end_angle;

  modport source (output valid, output center_x, output center_y, output arc_reversed,
                  output start_angle, output end_angle, input ready);
  modport sink (input valid, input center_x, input center_y, input arc_reversed,
                input start_angle, input end_angle, output ready);
endinterface

[design/afcr_vec.sv]
// pipelined cordic in vectoring mode: angle and scaled length of (x, y)
module afcr_vec #(
  parameter int IW     = 33,
  parameter int SW     = 1,
  parameter int STAGES = afcr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_x,
  input  logic signed [IW-1:0] in_y,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic [31:0]          out_ang,
  output logic signed [IW+10:0] out_x,
  output logic [SW-1:0]        out_side
);
  localparam int VW = IW + 11;

  logic                 vld  [0:STAGES];
  logic                 zero [0:STAGES];
  logic signed [VW-1:0] x    [0:STAGES];
  logic signed [VW-1:0] y    [0:STAGES];
  logic [31:0]          a    [0:STAGES];
  logic [SW-1:0]        side [0:STAGES];
  logic signed [VW-1:0] xe;
  logic signed [VW-1:0] ye;

  assign xe = VW'(in_x) <<< afcr_pkg::GUARD_BITS;
  assign ye = VW'(in_y) <<< afcr_pkg::GUARD_BITS;

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      zero[0] <= (in_x == '0) && (in_y == '0);
      side[0] <= in_side;
      if (xe < 0) begin
        x[0] <= -xe;
        y[0] <= -ye;
        a[0] <= 32'h8000_0000;
      end else begin
        x[0] <= xe;
        y[0] <= ye;
        a[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        zero[i+1] <= zero[i];
        side[i+1] <= side[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          a[i+1] <= a[i] + afcr_pkg::ATAN_TURN[i];
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          a[i+1] <= a[i] - afcr_pkg::ATAN_TURN[i];
        end
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_ang   = zero[STAGES] ? '0 : a[STAGES];
  assign out_x     = x[STAGES];
  assign out_side  = side[STAGES];
endmodule

[design/afcr_rot.sv]
// pipelined cordic in rotation mode: q30 unit vector at a 2^-32 turn angle
module afcr_rot #(
  parameter int SW     = 1,
  parameter int STAGES = afcr_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        in_ang,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic signed [32:0] out_c,
  output logic signed [32:0] out_s,
  output logic [SW-1:0]      out_side
);
  localparam int RW = 33;
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(34'sd1 <<< 30);
  localparam logic signed [ZW-1:0] HALF    = ZW'(34'sd1 <<< 31);

  logic                 vld  [0:STAGES];
  logic                 neg  [0:STAGES];
  logic signed [RW-1:0] x    [0:STAGES];
  logic signed [RW-1:0] y    [0:STAGES];
  logic signed [ZW-1:0] z    [0:STAGES];
  logic [SW-1:0]        side [0:STAGES];
  logic signed [ZW-1:0] zin;

  assign zin = ZW'($signed(in_ang));

  // bring the angle into the right half plane
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      side[0] <= in_side;
      x[0]    <= $signed(afcr_pkg::INV_GAIN_Q30);
      y[0]    <= '0;
      if (zin > QUARTER) begin
        z[0]   <= zin - HALF;
        neg[0] <= 1'b1;
      end else if (zin < -QUARTER) begin
        z[0]   <= zin + HALF;
        neg[0] <= 1'b1;
      end else begin
        z[0]   <= zin;
        neg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [RW-1:0] xs;
    logic signed [RW-1:0] ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        neg[i+1]  <= neg[i];
        side[i+1] <= side[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - ZW'(afcr_pkg::ATAN_TURN[i]);
        end else begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + ZW'(afcr_pkg::ATAN_TURN[i]);
        end
      end
    end
  end

  // undo the half turn fold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STAGES];
    end
    if (en) begin
      out_side <= side[STAGES];
      out_c    <= neg[STAGES] ? -x[STAGES] : x[STAGES];
      out_s    <= neg[STAGES] ? -y[STAGES] : y[STAGES];
    end
  end
endmodule

[design/arc_from_chord_and_radius_top.sv]
// Arc through a configured start point and a streamed end point with a configured
// radius. Each transaction on point gives one transaction on arc: the center
// (Q16.16, saturated), the direction flag and the angles from the center to the start
// and to the end point, which is pulled to one diameter from the start when the chord
// is longer. The block is a single pipeline that takes one transaction every cycle
// unless a result waits on arc; it includes three cordic pipelines (chord vectoring,
// unit vector rotation, then the two angle vectorings side by side) and the 31-step
// square root. While a result waits on arc the whole pipeline holds. Configuration
// writes are taken at any time on cfg, one per cycle, and must be made only with the
// pipeline empty.
module arc_from_chord_and_radius_top #(
  parameter int COORD_WIDTH   = afcr_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = afcr_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = afcr_pkg::CORDIC_STAGES_DEF
) (
  input logic        clk,
  input logic        rst,
  afcr_cfg_if.sink   cfg,
  afcr_in_if.sink    point,
  afcr_out_if.source arc
);
  localparam int CW   = COORD_WIDTH;
  localparam int AW   = ANGLE_WIDTH;
  localparam int NS   = CORDIC_STAGES;
  localparam int RDW  = afcr_pkg::RADIUS_W;
  localparam int GB   = afcr_pkg::GUARD_BITS;
  // chord vectoring widths
  localparam int IW1  = CW + 1;
  localparam int VW1  = IW1 + 11;
  localparam int HW   = (VW1 > 32) ? VW1 - 32 : 1;
  localparam int UW   = 32 + HW;
  localparam int LW   = HW + 33;
  localparam int CMPW = (LW > RDW + GB + 1) ? LW : RDW + GB + 1;
  localparam int HSW  = (LW + 1 > RDW + GB + 1) ? LW + 1 : RDW + GB + 1;
  // clamped end point, midpoint and center
  localparam int XW   = ((CW > 36) ? CW : 36) + 2;
  localparam int IW2  = XW + 1;
  localparam int DRW  = 34;
  localparam int SQ   = RDW;
  localparam int SQW  = 2 * RDW;
  localparam int S1W  = 2 * CW + 1;
  localparam int S2W  = LW + S1W;
  localparam int SQSW = 4 * XW + 2 * DRW + 1;

  localparam logic signed [XW-1:0] CMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] CMIN = ~CMAX;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = v;
    if (v > CMAX) begin
      t = CMAX;
    end else if (v < CMIN) begin
      t = CMIN;
    end
    return t[CW-1:0];
  endfunction

  // round a 2^-32 turn angle to the output resolution
  function automatic logic [AW-1:0] out_angle(input logic [31:0] a);
    logic [31:0] r;
    r = a + (32'd1 << (31 - AW));
    return r[31 -: AW];
  endfunction

  // configuration registers
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic [RDW-1:0]       arc_radius;
  logic                 reverse_side;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_y      <= '0;
      arc_radius   <= afcr_pkg::RADIUS_RESET;
      reverse_side <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        afcr_pkg::REG_START_X:      start_x      <= cfg.data[CW-1:0];
        afcr_pkg::REG_START_Y:      start_y      <= cfg.data[CW-1:0];
        afcr_pkg::REG_ARC_RADIUS:   arc_radius   <= cfg.data[RDW-1:0];
        afcr_pkg::REG_REVERSE_SIDE: reverse_side <= cfg.data[0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // one enable for the whole pipeline: it moves unless a result waits on arc
  logic en;
  assign en          = !arc.valid || arc.ready;
  assign point.ready = en;

  // chord vector
  logic                  s0_valid;
  logic signed [IW1-1:0] s0_dx;
  logic signed [IW1-1:0] s0_dy;
  logic signed [CW-1:0]  s0_ex;
  logic signed [CW-1:0]  s0_ey;
  logic                  s0_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= point.valid;
    end
    if (en) begin
      s0_dx   <= IW1'(point.end_x) - IW1'(start_x);
      s0_dy   <= IW1'(point.end_y) - IW1'(start_y);
      s0_ex   <= point.end_x;
      s0_ey   <= point.end_y;
      s0_flip <= point.flip_direction;
    end
  end

  // chord angle and guarded length
  logic                  v1_valid;
  logic [31:0]           v1_ang;
  logic signed [VW1-1:0] v1_x;
  logic [S1W-1:0]        v1_side;

  afcr_vec #(
    .IW     (IW1),
    .SW     (S1W),
    .STAGES (NS)
  ) u_chord_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .in_x      (s0_dx),
    .in_y      (s0_dy),
    .in_side   ({s0_ex, s0_ey, s0_flip}),
    .out_valid (v1_valid),
    .out_ang   (v1_ang),
    .out_x     (v1_x),
    .out_side  (v1_side)
  );

  // length times 1/K, split into two partial products
  logic [VW1-1:0] v1_ux;
  logic [UW-1:0]  v1_uxe;
  assign v1_ux  = v1_x[VW1-1] ? '0 : $unsigned(v1_x);
  assign v1_uxe = UW'(v1_ux);

  logic           m1_valid;
  logic [HW+31:0] m1_hp;
  logic [63:0]    m1_lp;
  logic [31:0]    m1_ang;
  logic [S1W-1:0] m1_side;
  logic           m2_valid;
  logic [LW-1:0]  m2_len;
  logic [31:0]    m2_ang;
  logic [S1W-1:0] m2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= v1_valid;
      m2_valid <= m1_valid;
    end
    if (en) begin
      m1_hp   <= v1_uxe[UW-1:32] * afcr_pkg::INV_GAIN;
      m1_lp   <= v1_uxe[31:0] * afcr_pkg::INV_GAIN;
      m1_ang  <= v1_ang;
      m1_side <= v1_side;
      m2_len  <= LW'(m1_hp) + LW'(m1_lp[63:32]);
      m2_ang  <= m1_ang;
      m2_side <= m1_side;
    end
  end

  // chord direction as a q30 unit vector
  logic               r_valid;
  logic signed [32:0] r_c;
  logic signed [32:0] r_s;
  logic [S2W-1:0]     r_side;

  afcr_rot #(
    .SW     (S2W),
    .STAGES (NS)
  ) u_dir_rot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .in_ang    (m2_ang),
    .in_side   ({m2_len, m2_side}),
    .out_valid (r_valid),
    .out_c     (r_c),
    .out_s     (r_s),
    .out_side  (r_side)
  );

  logic [LW-1:0]        r_len;
  logic signed [CW-1:0] r_ex;
  logic signed [CW-1:0] r_ey;
  logic [HSW-1:0]       r_hsum;
  assign r_len  = r_side[S2W-1 -: LW];
  assign r_ex   = r_side[S1W-1 -: CW];
  assign r_ey   = r_side[CW:1];
  assign r_hsum = HSW'(r_len) + (HSW'(1) << GB);

  // stage a: chord too long for the radius, scaled direction, rounded half chord
  logic                  a_valid;
  logic signed [64:0]    a_pcx;
  logic signed [64:0]    a_pcy;
  logic                  a_big;
  logic [RDW-1:0]        a_hqu;
  logic signed [CW-1:0]  a_ex;
  logic signed [CW-1:0]  a_ey;
  logic signed [DRW-1:0] a_dirx;
  logic signed [DRW-1:0] a_diry;
  logic                  a_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= r_valid;
    end
    if (en) begin
      a_pcx  <= $signed({1'b0, arc_radius}) * r_c;
      a_pcy  <= $signed({1'b0, arc_radius}) * r_s;
      a_big  <= CMPW'(r_len) >= CMPW'({arc_radius, {(GB + 1){1'b0}}});
      a_hqu  <= r_hsum[GB+1 +: RDW];
      a_ex   <= r_ex;
      a_ey   <= r_ey;
      a_flip <= r_side[0];
      // normal toward the chosen side
      if (reverse_side) begin
        a_dirx <= DRW'(r_s);
        a_diry <= -DRW'(r_c);
      end else begin
        a_dirx <= -DRW'(r_s);
        a_diry <= DRW'(r_c);
      end
    end
  end

  // stage b: clamped end point and half chord
  logic                  b_valid;
  logic signed [XW-1:0]  b_ex2;
  logic signed [XW-1:0]  b_ey2;
  logic [RDW-1:0]        b_hq;
  logic signed [DRW-1:0] b_dirx;
  logic signed [DRW-1:0] b_diry;
  logic                  b_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      if (a_big) begin
        b_ex2 <= XW'(start_x) + XW'(a_pcx >>> 29);
        b_ey2 <= XW'(start_y) + XW'(a_pcy >>> 29);
        b_hq  <= arc_radius;
      end else begin
        b_ex2 <= XW'(a_ex);
        b_ey2 <= XW'(a_ey);
        b_hq  <= a_hqu;
      end
      b_dirx <= a_dirx;
      b_diry <= a_diry;
      b_flip <= a_flip;
    end
  end

  // stage c: midpoint and squares for the offset
  logic                  c_valid;
  logic signed [XW-1:0]  c_mx;
  logic signed [XW-1:0]  c_my;
  logic signed [XW-1:0]  c_ex2;
  logic signed [XW-1:0]  c_ey2;
  logic [SQW-1:0]        c_rr;
  logic [SQW-1:0]        c_hh;
  logic                  c_dpos;
  logic signed [DRW-1:0] c_dirx;
  logic signed [DRW-1:0] c_diry;
  logic                  c_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_mx   <= (XW'(start_x) + b_ex2) >>> 1;
      c_my   <= (XW'(start_y) + b_ey2) >>> 1;
      c_ex2  <= b_ex2;
      c_ey2  <= b_ey2;
      c_rr   <= arc_radius * arc_radius;
      c_hh   <= b_hq * b_hq;
      c_dpos <= arc_radius > b_hq;
      c_dirx <= b_dirx;
      c_diry <= b_diry;
      c_flip <= b_flip;
    end
  end

  // square root, one result bit per stage
  logic            sq_valid [0:SQ];
  logic [SQW-1:0]  sq_n     [0:SQ];
  logic [SQW-1:0]  sq_res   [0:SQ];
  logic [SQSW-1:0] sq_side  [0:SQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= c_valid;
    end
    if (en) begin
      sq_n[0]    <= c_dpos ? c_rr - c_hh : '0;
      sq_res[0]  <= '0;
      sq_side[0] <= {c_mx, c_my, c_ex2, c_ey2, c_dirx, c_diry, c_flip};
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
    logic [SQW:0] trial;
    assign trial = (SQW + 1)'(sq_res[k]) + (SQW + 1)'(BIT);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (en) begin
        sq_valid[k+1] <= sq_valid[k];
      end
      if (en) begin
        sq_side[k+1] <= sq_side[k];
        if ((SQW + 1)'(sq_n[k]) >= trial) begin
          sq_n[k+1]   <= sq_n[k] - trial[SQW-1:0];
          sq_res[k+1] <= (sq_res[k] >> 1) + BIT;
        end else begin
          sq_n[k+1]   <= sq_n[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
      end
    end
  end

  logic [RDW-1:0]        sq_d;
  logic signed [XW-1:0]  sq_mx;
  logic signed [XW-1:0]  sq_my;
  logic signed [XW-1:0]  sq_ex2;
  logic signed [XW-1:0]  sq_ey2;
  logic signed [DRW-1:0] sq_dirx;
  logic signed [DRW-1:0] sq_diry;

  assign sq_d    = sq_res[SQ][RDW-1:0];
  assign sq_mx   = sq_side[SQ][SQSW-1 -: XW];
  assign sq_my   = sq_side[SQ][SQSW-1-XW -: XW];
  assign sq_ex2  = sq_side[SQ][SQSW-1-2*XW -: XW];
  assign sq_ey2  = sq_side[SQ][SQSW-1-3*XW -: XW];
  assign sq_dirx = sq_side[SQ][2*DRW:DRW+1];
  assign sq_diry = sq_side[SQ][DRW:1];

  // stages e and f: offset along the normal, then the center
  logic                 e_valid;
  logic signed [65:0]   e_pdx;
  logic signed [65:0]   e_pdy;
  logic signed [XW-1:0] e_mx;
  logic signed [XW-1:0] e_my;
  logic signed [XW-1:0] e_ex2;
  logic signed [XW-1:0] e_ey2;
  logic                 e_flip;
  logic                 f_valid;
  logic signed [XW-1:0] f_cx;
  logic signed [XW-1:0] f_cy;
  logic signed [XW-1:0] f_ex2;
  logic signed [XW-1:0] f_ey2;
  logic                 f_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      e_valid <= sq_valid[SQ];
      f_valid <= e_valid;
    end
    if (en) begin
      e_pdx  <= $signed({1'b0, sq_d}) * sq_dirx;
      e_pdy  <= $signed({1'b0, sq_d}) * sq_diry;
      e_mx   <= sq_mx;
      e_my   <= sq_my;
      e_ex2  <= sq_ex2;
      e_ey2  <= sq_ey2;
      e_flip <= sq_side[SQ][0];
      f_cx   <= e_mx + XW'(e_pdx >>> 30);
      f_cy   <= e_my + XW'(e_pdy >>> 30);
      f_ex2  <= e_ex2;
      f_ey2  <= e_ey2;
      f_flip <= e_flip;
    end
  end

  // stage g: vectors from the unsaturated center, saturated center for output
  logic                  g_valid;
  logic signed [IW2-1:0] g_v1x;
  logic signed [IW2-1:0] g_v1y;
  logic signed [IW2-1:0] g_v2x;
  logic signed [IW2-1:0] g_v2y;
  logic signed [CW-1:0]  g_cx;
  logic signed [CW-1:0]  g_cy;
  logic                  g_rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
    if (en) begin
      g_v1x <= IW2'(start_x) - IW2'(f_cx);
      g_v1y <= IW2'(start_y) - IW2'(f_cy);
      g_v2x <= IW2'(f_ex2) - IW2'(f_cx);
      g_v2y <= IW2'(f_ey2) - IW2'(f_cy);
      g_cx  <= sat_coord(f_cx);
      g_cy  <= sat_coord(f_cy);
      g_rev <= reverse_side ^ f_flip;
    end
  end

  // start and end angles, two vectoring pipelines in step
  logic              w_valid;
  logic [31:0]       w_ang1;
  logic [31:0]       w_ang2;
  logic [2*CW-1:0]   w_side1;
  logic              w_rev;

  afcr_vec #(
    .IW     (IW2),
    .SW     (2 * CW),
    .STAGES (NS)
  ) u_start_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_x      (g_v1x),
    .in_y      (g_v1y),
    .in_side   ({g_cx, g_cy}),
    .out_valid (w_valid),
    .out_ang   (w_ang1),
    .out_x     (),
    .out_side  (w_side1)
  );

  afcr_vec #(
    .IW     (IW2),
    .SW     (1),
    .STAGES (NS)
  ) u_end_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_x      (g_v2x),
    .in_y      (g_v2y),
    .in_side   (g_rev),
    .out_valid (),
    .out_ang   (w_ang2),
    .out_x     (),
    .out_side  (w_rev)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      arc.valid <= 1'b0;
    end else if (en) begin
      arc.valid <= w_valid;
    end
    if (en) begin
      arc.center_x     <= w_side1[2*CW-1:CW];
      arc.center_y     <= w_side1[CW-1:0];
      arc.arc_reversed <= w_rev;
      arc.start_angle  <= out_angle(w_ang1);
      arc.end_angle    <= out_angle(w_ang2);
    end
  end

  // half chord never exceeds the radius once clamped
  assert property (@(posedge clk) disable iff (rst) b_valid |-> b_hq <= arc_radius)
    else $error("half chord above radius");

  // the offset from the square root stays within the radius
  assert property (@(posedge clk) disable iff (rst) sq_valid[SQ] |-> sq_d <= arc_radius)
    else $error("center offset above radius");

  // the radicand is cleared when the radius does not exceed the half chord
  assert property (@(posedge clk) disable iff (rst)
    (c_valid && en && !c_dpos) |=> sq_n[0] == '0)
    else $error("radicand not cleared");

  // input is held back only while a result waits
  assert property (@(posedge clk) disable iff (rst)
    !point.ready |-> (arc.valid && !arc.ready))
    else $error("pipeline stalled without a waiting result");
endmodule

[test/tb_arc_scoreboard.sv]
// scoreboard for the arc block: predicts one arc per end point and checks results
class arc_scoreboard;
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               rev;
    logic [15:0]        a_start;
    logic [15:0]        a_end;
  } arc_t;

  longint sx, sy, radius;
  bit     side;
  arc_t   pending_arcs[$];
  int     errors;

  function new();
    sx = 0; sy = 0; radius = 65536; side = 0; errors = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [31:0] data);
    case (idx)
      afcr_pkg::REG_START_X:      sx = longint'(signed'(data));
      afcr_pkg::REG_START_Y:      sy = longint'(signed'(data));
      afcr_pkg::REG_ARC_RADIUS:   radius = longint'(data[30:0]);
      afcr_pkg::REG_REVERSE_SIDE: side = data[0];
      default: ;
    endcase
  endfunction

  // arithmetic shift that floors
  function longint shr(longint v, int n);
    return v >>> n;
  endfunction

  function logic [31:0] angle_of(longint x, longint y, output longint len);
    logic [31:0] a;
    longint xs, ys;
    logic [63:0] ux;
    a = 0;
    if (x == 0 && y == 0) begin
      len = 0;
      return 0;
    end
    x = x * 256; y = y * 256;
    if (x < 0) begin
      x = -x; y = -y; a = 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; a += afcr_pkg::ATAN_TURN[i];
      end else begin
        x -= ys; y += xs; a -= afcr_pkg::ATAN_TURN[i];
      end
    end
    if (x < 0) x = 0;
    ux = x;
    len = longint'((ux >> 32) * 64'(afcr_pkg::INV_GAIN)
        + (((ux & 64'hFFFFFFFF) * 64'(afcr_pkg::INV_GAIN)) >> 32));
    return a;
  endfunction

  function void unit_dir(logic [31:0] t, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit neg;
    z = t; x = longint'(afcr_pkg::INV_GAIN_Q30); y = 0; neg = 0;
    if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
    if (z > (64'sd1 << 30)) begin
      z -= (64'sd1 << 31); neg = 1;
    end else if (z < -(64'sd1 << 30)) begin
      z += (64'sd1 << 31); neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(afcr_pkg::ATAN_TURN[i]);
      end else begin
        x += ys; y -= xs; z += longint'(afcr_pkg::ATAN_TURN[i]);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function logic [31:0] clamp(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function logic [15:0] round_angle(logic [31:0] a);
    logic [31:0] r;
    r = a + (32'd1 << 15);
    return r[31:16];
  endfunction

  function void note_point(logic [31:0] ex_in, logic [31:0] ey_in, bit flip);
    longint ex, ey, len, c, s, mx, my, d, dx, dy, cx, cy, dummy, half;
    logic [31:0] chord, a1, a2;
    arc_t e;
    ex = longint'(signed'(ex_in)); ey = longint'(signed'(ey_in)); d = 0;
    chord = angle_of(ex - sx, ey - sy, len);
    unit_dir(chord, c, s);
    if (len >= 2 * radius * 256) begin
      ex = sx + shr(2 * radius * c, 30);
      ey = sy + shr(2 * radius * s, 30);
      half = radius;
    end else half = (len + 256) >> 9;
    mx = shr(sx + ex, 1);
    my = shr(sy + ey, 1);
    if (radius - half > 0) d = longint'(int_sqrt(64'(radius * radius - half * half)));
    if (side) begin
      dx = s; dy = -c;
    end else begin
      dx = -s; dy = c;
    end
    cx = mx + shr(d * dx, 30);
    cy = my + shr(d * dy, 30);
    a1 = angle_of(sx - cx, sy - cy, dummy);
    a2 = angle_of(ex - cx, ey - cy, dummy);
    e.cx = clamp(cx); e.cy = clamp(cy); e.rev = side ^ flip;
    e.a_start = round_angle(a1); e.a_end = round_angle(a2);
    pending_arcs.push_back(e);
  endfunction

  function void check_arc(arc_t got);
    arc_t e;
    if (pending_arcs.size() == 0) begin
      $display("%0t unexpected arc %h", $time, got);
      errors++;
      return;
    end
    e = pending_arcs.pop_front();
    if (got.cx !== e.cx) begin
      $display("%0t center_x exp %h got %h", $time, e.cx, got.cx); errors++;
    end
    if (got.cy !== e.cy) begin
      $display("%0t center_y exp %h got %h", $time, e.cy, got.cy); errors++;
    end
    if (got.rev !== e.rev) begin
      $display("%0t arc_reversed exp %b got %b", $time, e.rev, got.rev); errors++;
    end
    if (got.a_start !== e.a_start) begin
      $display("%0t start_angle exp %h got %h", $time, e.a_start, got.a_start); errors++;
    end
    if (got.a_end !== e.a_end) begin
      $display("%0t end_angle exp %h got %h", $time, e.a_end, got.a_end); errors++;
    end
  endfunction
endclass

[test/tb.sv]
module tb;

  localparam int LATENCY = 94;
  localparam int WATCHDOG = 4000;

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  afcr_cfg_if #(.DW(32)) cfg ();
  afcr_in_if #(.CW(32)) point ();
  afcr_out_if #(.CW(32), .AW(16)) arc ();

  arc_from_chord_and_radius_top uut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .point(point.sink), .arc(arc.source)
  );

  arc_scoreboard sb;
  bit quiet_tail;   // no idling near the end
  int idle_cycles;

  // sink side: random stall bursts, check each transaction at the rising edge
  initial begin
    int hold;
    arc.ready = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (quiet_tail || rst) arc.ready <= !rst;
      else if (hold > 0) begin
        hold--;
        arc.ready <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 18) - 1;
        arc.ready <= 0;
      end else arc.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && arc.valid && arc.ready)
      sb.check_arc({arc.center_x, arc.center_y, arc.arc_reversed,
                    arc.start_angle, arc.end_angle});
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (point.valid && point.ready) || (arc.valid && arc.ready) ||
        (cfg.valid && cfg.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: errors");
      $finish;
    end
  end

  // valid stays high across back to back writes, stop_cfg lowers it
  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic stop_cfg();
    cfg.valid <= 0;
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    while (sb.pending_arcs.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, bit flip);
    if (!quiet_tail && $urandom_range(0, 11) == 0) begin
      point.valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    point.valid <= 1; point.end_x <= x; point.end_y <= y; point.flip_direction <= flip;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
    sb.note_point(x, y, flip);
    @(negedge clk);
  endtask

  task automatic stop_points();
    point.valid <= 0;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
      default: return $urandom_range(0, 32'h3FFFFF) - 32'h200000;
    endcase
  endfunction

  initial begin
    logic [31:0] base_x, base_y;
    int mode;
    sb = new();
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    point.valid = 0; point.end_x = 0; point.end_y = 0; point.flip_direction = 0;
    quiet_tail = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset settings, coincident point, extremes, long chords
    send_point(0, 0, 0);
    send_point(0, 0, 1);
    send_point(32'h00010000, 0, 0);
    send_point(32'h00008000, 32'h00008000, 1);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_point(32'h80000000, 32'h80000000, 1);
    send_point(32'h80000000, 32'h7FFFFFFF, 0);
    send_point(32'hFFFFFFFF, 32'h00000001, 1);
    stop_points();
    drain();
    // zero radius, reverse side, unused index
    write_reg(afcr_pkg::REG_ARC_RADIUS, 0);
    write_reg(afcr_pkg::REG_REVERSE_SIDE, 1);
    write_reg(8'd7, 32'hDEADBEEF);
    stop_cfg();
    send_point(32'h00030000, 32'h00020000, 0);
    send_point(0, 0, 1);
    stop_points();
    drain();
    // largest radius, extreme start
    write_reg(afcr_pkg::REG_ARC_RADIUS, 32'h7FFFFFFF);
    write_reg(afcr_pkg::REG_START_X, 32'h80000000);
    write_reg(afcr_pkg::REG_START_Y, 32'h7FFFFFFF);
    stop_cfg();
    send_point(32'h80000000, 32'h7FFFFFFF, 0);
    send_point(32'h7FFFFFFF, 32'h80000000, 1);
    send_point(0, 0, 0);
    stop_points();
    drain();
    write_reg(afcr_pkg::REG_START_X, 32'h7FFFFFFF);
    write_reg(afcr_pkg::REG_START_Y, 32'h80000000);
    write_reg(afcr_pkg::REG_REVERSE_SIDE, 0);
    stop_cfg();
    send_point(32'h80000000, 32'h7FFFFFFF, 1);
    send_point(32'h7FFFFFFF, 32'h80000000, 0);
    stop_points();
    drain();

    // random phases: new settings each phase, points mostly near the start
    for (int ph = 0; ph < 16; ph++) begin
      mode = $urandom_range(0, 3);
      base_x = (mode == 0) ? $urandom() : $urandom_range(0, 32'hFFFFF) - 32'h80000;
      base_y = (mode == 0) ? $urandom() : $urandom_range(0, 32'hFFFFF) - 32'h80000;
      write_reg(afcr_pkg::REG_START_X, base_x);
      write_reg(afcr_pkg::REG_START_Y, base_y);
      case ($urandom_range(0, 3))
        0: write_reg(afcr_pkg::REG_ARC_RADIUS, $urandom());
        1: write_reg(afcr_pkg::REG_ARC_RADIUS, $urandom_range(0, 32'h80000));
        default: write_reg(afcr_pkg::REG_ARC_RADIUS, $urandom_range(1, 32'h400000));
      endcase
      write_reg(afcr_pkg::REG_REVERSE_SIDE, $urandom());
      stop_cfg();
      if (ph == 15) quiet_tail = 1;
      for (int i = 0; i < 100; i++) begin
        if (mode == 0 || $urandom_range(0, 7) == 0)
          send_point($urandom(), $urandom(), 1'($urandom()));
        else
          send_point(base_x + rand_coord(mode), base_y + rand_coord(mode),
                     1'($urandom()));
      end
      stop_points();
      drain();
    end

    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

[sim.f]
design/afcr_pkg.sv
design/afcr_if.sv
design/afcr_vec.sv
design/afcr_rot.sv
design/arc_from_chord_and_radius_top.sv
test/tb_arc_scoreboard.sv
test/tb.sv
